// ----- rtl/core/bkm_pkg.sv -----
`timescale 1ns / 1ps

package bkm_pkg;

  // Default build values.
  localparam int PHASE_BITS_DEF  = 32;
  localparam int TABLE_BITS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  // Register field widths.
  localparam int AMP_W  = 16;
  localparam int STEP_W = 31;
  localparam int OFFS_W = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Quarter-wave sine entries, unsigned Q1.30 in [0, 1.0].
  localparam int SINE_W = 31;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q30 = 64'sd1073741824;

  // Register reset values.
  localparam logic [AMP_W-1:0]  AMP_RST  = 16'd8192;
  localparam logic [STEP_W-1:0] STEP_RST = 31'd8589935;
  localparam logic [OFFS_W-1:0] OFFS_RST = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMP_ZERO    = 3'd0,
    REG_AMP_ONE     = 3'd1,
    REG_STEP_ZERO   = 3'd2,
    REG_STEP_ONE    = 3'd3,
    REG_OFFSET_ZERO = 3'd4,
    REG_OFFSET_ONE  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [AMP_W-1:0] amp_zero;
    logic signed [AMP_W-1:0] amp_one;
    logic [STEP_W-1:0]       step_zero;
    logic [STEP_W-1:0]       step_one;
    logic [OFFS_W-1:0]       offset_zero;
    logic [OFFS_W-1:0]       offset_one;
  } bkm_cfg_t;

endpackage

// ----- rtl/core/bkm_bit_if.sv -----
`timescale 1ns / 1ps

interface bkm_bit_if ();

  logic valid;
  logic ready;
  logic data_bit;

  modport source (output valid, output data_bit, input ready);
  modport sink   (input valid, input data_bit, output ready);

endinterface

// ----- rtl/core/bkm_sample_if.sv -----
`timescale 1ns / 1ps

interface bkm_sample_if import bkm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

// ----- rtl/core/binary_keying_modulator.sv -----
`timescale 1ns / 1ps

// Binary ASK/FSK/PSK modulator on a phase-continuous NCO. Every accepted
// transaction on in_i carries the data bit for one sample period and yields
// exactly one signed sample on out_o: amp * sin(phase + offset), with amp,
// step and offset picked by the bit, rounded half up and saturated. Throughput
// is one sample per clock while out_o is ready; the only loop is the phase
// accumulator add. A sample passes three registered stages (phase add and sine
// ROM address, registered sine read; multiply; round/saturate into the output
// register); back-pressure on out_o fills the three stages before in_i stalls.
// After reset the sine ROM loads 2^TABLE_BITS + 1 entries (1025 by default)
// and in_i.ready stays low until then. Registers are written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must do so only while no
// transaction is in flight (unenforced); writes past the last register drop.
module binary_keying_modulator import bkm_pkg::*; #(
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int TABLE_BITS  = TABLE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bkm_bit_if.sink               in_i,
  bkm_sample_if.source          out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int AW     = TABLE_BITS + 1;
  localparam int PROD_W = 48;
  localparam int SH     = 46 - SAMPLE_BITS;   // product LSB weight vs sample LSB

  localparam logic [AW-1:0] QUARTER = AW'(1) << TABLE_BITS;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (SH - 1);
  localparam logic signed [PROD_W-1:0] SAT_HI   = (PROD_W'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [PROD_W-1:0] SAT_LO   = -SAT_HI - 1;

  // ---------------------------------------------------------------- config
  bkm_cfg_t cfg;

  bkm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // ------------------------------------------------------- stage handshake
  // Each stage advances when the one after it is empty or moving, so
  // bubbles collapse and a waiting output does not block an empty pipe.
  logic va_q, vb_q, vc_q;
  logic en_a, en_b, en_c;
  logic rom_ready;
  logic accept;

  assign en_c   = !vc_q || out_o.ready;
  assign en_b   = !vb_q || en_c;
  assign en_a   = !va_q || en_b;
  assign in_i.ready = en_a && rom_ready;
  assign accept = in_i.valid && in_i.ready;

  // ------------------------------------------- stage A: phase and ROM addr
  logic signed [AMP_W-1:0]  amp_sel;
  logic [STEP_W-1:0]        step_sel;
  logic [OFFS_W-1:0]        offs_sel;
  logic [PHASE_BITS-1:0]    step_ph, offs_ph;
  logic [PHASE_BITS-1:0]    phase_acc_q, phase_acc_d;
  logic [PHASE_BITS-1:0]    phase_sum;
  logic [1:0]               quad;
  logic [TABLE_BITS-1:0]    tab_k;
  logic [AW-1:0]            rom_addr;
  logic signed [AMP_W:0]    amp_ext;
  logic signed [AMP_W:0]    amp_a_d, amp_a_q;
  logic [SINE_W-1:0]        sine_a;

  assign amp_sel  = in_i.data_bit ? cfg.amp_one     : cfg.amp_zero;
  assign step_sel = in_i.data_bit ? cfg.step_one    : cfg.step_zero;
  assign offs_sel = in_i.data_bit ? cfg.offset_one  : cfg.offset_zero;

  // Steps and offsets are in units of 2^-32 turn.
  if (PHASE_BITS >= 32) begin : g_ph_wide
    assign step_ph = PHASE_BITS'(step_sel) << (PHASE_BITS - 32);
    assign offs_ph = PHASE_BITS'(offs_sel) << (PHASE_BITS - 32);
  end else begin : g_ph_narrow
    assign step_ph = PHASE_BITS'(step_sel >> (32 - PHASE_BITS));
    assign offs_ph = PHASE_BITS'(offs_sel >> (32 - PHASE_BITS));
  end

  assign phase_sum = phase_acc_q + offs_ph;
  assign quad      = phase_sum[PHASE_BITS-1 -: 2];
  assign tab_k     = phase_sum[PHASE_BITS-3 -: TABLE_BITS];

  // Odd quadrants run the table backwards, lower half-turn negates.
  assign rom_addr = quad[0] ? (QUARTER - {1'b0, tab_k}) : {1'b0, tab_k};
  assign amp_ext  = {amp_sel[AMP_W-1], amp_sel};
  assign amp_a_d  = quad[1] ? -amp_ext : amp_ext;

  // Accumulator is never cleared between bits: phase stays continuous.
  assign phase_acc_d = accept ? (phase_acc_q + step_ph) : phase_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
    end else begin
      phase_acc_q <= phase_acc_d;
    end
  end

  bkm_sine_rom #(
    .TABLE_BITS (TABLE_BITS)
  ) u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (en_a),
    .raddr_i (rom_addr),
    .rdata_o (sine_a),
    .ready_o (rom_ready)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      amp_a_q <= amp_a_d;
    end
  end

  // ------------------------------------------------------ stage B: multiply
  logic signed [SINE_W:0]   sine_s;
  logic signed [PROD_W:0]   prod_full;
  logic signed [PROD_W-1:0] prod_b_q;

  assign sine_s    = {1'b0, sine_a};
  assign prod_full = amp_a_q * sine_s;

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      prod_b_q <= prod_full[PROD_W-1:0];
    end
  end

  // ------------------------------------------ stage C: round and saturate
  logic signed [PROD_W-1:0]      rnd_sum;
  logic signed [PROD_W-1:0]      rnd_q;
  logic signed [SAMPLE_BITS-1:0] sample_d, sample_q;

  assign rnd_sum = prod_b_q + RND_HALF;
  assign rnd_q   = rnd_sum >>> SH;

  always_comb begin
    if (rnd_q > SAT_HI) begin
      sample_d = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rnd_q < SAT_LO) begin
      sample_d = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sample_d = rnd_q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c && vb_q) begin
      sample_q <= sample_d;
    end
  end

  // ------------------------------------------------------------ valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= accept;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
    end
  end

  assign out_o.valid  = vc_q;
  assign out_o.sample = sample_q;

endmodule

// ----- rtl/core/bkm_ram.sv -----
`timescale 1ns / 1ps

module bkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bkm_sine_rom.sv -----
`timescale 1ns / 1ps

// Quarter-wave sine store. Entries are computed at elaboration and copied
// into the RAM one per cycle after reset; ready_o rises when the copy ends.
module bkm_sine_rom import bkm_pkg::*; #(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  re_i,
  input  logic [TABLE_BITS:0]   raddr_i,
  output logic [SINE_W-1:0]     rdata_o,
  output logic                  ready_o
);

  localparam int TAB_LEN = (1 << TABLE_BITS) + 1;
  localparam int AW      = TABLE_BITS + 1;
  localparam logic [AW-1:0] LAST = AW'(TAB_LEN - 1);

  // Eight-term fixed-point Taylor series, Q1.30 in and out, clamped to [0, 1].
  function automatic logic [SINE_W-1:0] sine_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned t;
    longint          sum;
    int              n;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 7; n++) begin
      t = (term * x2) >> 30;
      case (n)
        1:       term = t / 64'd6;
        2:       term = t / 64'd20;
        3:       term = t / 64'd42;
        4:       term = t / 64'd72;
        5:       term = t / 64'd110;
        6:       term = t / 64'd156;
        default: term = t / 64'd210;
      endcase
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return SINE_W'(sum);
  endfunction

  logic [SINE_W-1:0] tab_w [TAB_LEN];

  for (genvar k = 0; k < TAB_LEN; k++) begin : g_tab
    localparam longint unsigned X =
        (HALF_PI_Q30 * 64'(k) + (64'd1 << (TABLE_BITS - 1))) >> TABLE_BITS;
    localparam logic [SINE_W-1:0] VAL = sine_q30(X);
    assign tab_w[k] = VAL;
  end

  logic [AW-1:0] fill_cnt_q, fill_cnt_d;
  logic          done_q, done_d;
  logic          fill_we;

  assign fill_we = !done_q;

  always_comb begin
    fill_cnt_d = fill_cnt_q;
    done_d     = done_q;
    if (!done_q) begin
      if (fill_cnt_q == LAST) begin
        done_d = 1'b1;
      end else begin
        fill_cnt_d = fill_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      fill_cnt_q <= fill_cnt_d;
      done_q     <= done_d;
    end
  end

  bkm_ram #(
    .WIDTH (SINE_W),
    .DEPTH (TAB_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_cnt_q),
    .wdata_i (tab_w[fill_cnt_q]),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (rdata_o)
  );

  assign ready_o = done_q;

endmodule

// ----- rtl/core/bkm_cfg_regs.sv -----
`timescale 1ns / 1ps

module bkm_cfg_regs import bkm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] wdata_i,
  output bkm_cfg_t              cfg_o
);

  bkm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_reg_e'(idx_i))
        REG_AMP_ZERO:    cfg_d.amp_zero    = wdata_i[AMP_W-1:0];
        REG_AMP_ONE:     cfg_d.amp_one     = wdata_i[AMP_W-1:0];
        REG_STEP_ZERO:   cfg_d.step_zero   = wdata_i[STEP_W-1:0];
        REG_STEP_ONE:    cfg_d.step_one    = wdata_i[STEP_W-1:0];
        REG_OFFSET_ZERO: cfg_d.offset_zero = wdata_i[OFFS_W-1:0];
        REG_OFFSET_ONE:  cfg_d.offset_one  = wdata_i[OFFS_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amp_zero    <= AMP_RST;
      cfg_q.amp_one     <= AMP_RST;
      cfg_q.step_zero   <= STEP_RST;
      cfg_q.step_one    <= STEP_RST;
      cfg_q.offset_zero <= OFFS_RST;
      cfg_q.offset_one  <= OFFS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/bkm_checker.sv -----
`timescale 1ns / 1ps

module bkm_checker import bkm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_sample_i
);

  logic in_txn;
  logic drain;

  assign in_txn = in_valid_i && in_ready_i;
  assign drain  = out_ready_i && !in_txn;

  // A stalled sample stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("stalled output sample changed");

  // The sine ROM load keeps the input closed right after reset.
  a_load_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i)
    else $error("input open during sine ROM load");

  // Once open, the input stays open whenever the output side is not blocking.
  a_ready_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_ready_i) && (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled with free output");

  // Draining with no new transaction, once for each stage, empties the pipeline.
  a_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain && $past(drain) && $past(drain, 2) |=> !out_valid_i)
    else $error("sample appeared without an input transaction");

endmodule

bind binary_keying_modulator bkm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bkm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample)
);
